// File: rtl/core/ring_deque_engine_assert.svh
// Assertion macros shared by the deque checker
`ifndef RING_DEQUE_ENGINE_ASSERT_SVH
`define RING_DEQUE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RDE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// delayed implication, sampled on clk, off while in reset
`define RDE_ASSERT_LAT2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rde_pkg.sv
// Shared constants and types of the ring deque engine
package rde_pkg;

	localparam int DEPTH     = 16;
	localparam int ELEM_BITS = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam int OP_W    = 3;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 4;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ       = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// request metadata waiting for the memory read data
	typedef struct packed {
		logic               use_rd;
		status_t            status;
		logic [CNT_W-1:0]   count;
	} s1_t;

endpackage

// File: rtl/core/rde_ifs.sv
// Request and response channel interfaces of the ring deque engine
interface rde_in_if;
	import rde_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [DATA_W-1:0] push_data;
	logic [IDX_W-1:0]  index;

	modport source (output valid, op, push_data, index, input ready);
	modport sink   (input valid, op, push_data, index, output ready);
endinterface

interface rde_out_if;
	import rde_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  out_data;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] count;

	modport source (output valid, out_data, status, count, input ready);
	modport sink   (input valid, out_data, status, count, output ready);
endinterface

// File: rtl/core/ring_deque_engine.sv
// Ring deque engine: a double-ended queue in a circular one-port-read memory.
//
// req carries one operation per request: push front, push back, pop front,
// pop back or read at an index from the front. rsp returns one result per
// request, in order: the element popped or read (zero otherwise), a status
// (ok, full, empty, out of range) and the element count after the operation.
// cfg_we/cfg_wdata write the capacity register; write it only while idle.
//
// Head pointer and count update at the edge that accepts a request; the write
// or the synchronous read of the element memory happens at the same edge.
// The accepted request then waits in the s1 register with the read data and
// moves into the output register once that register is free or being taken;
// rsp.valid rises with it. Sustained rate is one request per cycle while rsp
// does not stall; a back-to-back read sees the write of the previous request
// since each memory access lands on its own edge.
// When rsp stalls, the output register and one request in flight hold, and
// req.ready drops until the output register frees.
// Reset clears head, count and the pipeline valids, and sets capacity to 16;
// the element memory is not cleared (unwritten entries are never returned).
module ring_deque_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rde_pkg::CAP_W-1:0]  cfg_wdata,
	rde_in_if.sink                     req,
	rde_out_if.source                  rsp
);
	import rde_pkg::*;

	logic [ELEM_BITS-1:0] mem [DEPTH];
	logic [ELEM_BITS-1:0] mem_rd_q;

	logic [CAP_W-1:0]   cap_q;
	logic [ADDR_W-1:0]  head_q;
	logic [CNT_W-1:0]   fill_q;

	s1_t                s1_q;
	logic               s1_vld_q;

	logic               out_vld_q;
	logic [DATA_W-1:0]  out_data_q;
	status_t            out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic               advance;
	logic [CNT_W-1:0]   eff_cap;
	logic               full;
	logic               empty;
	logic [ADDR_W-1:0]  nxt_head;
	logic [CNT_W-1:0]   nxt_fill;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_use;
	status_t            st;

	// ring position of the element at offset off from head, wrapping at DEPTH
	function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] h,
			input logic [CNT_W-1:0] off);
		logic [ADDR_W:0] s;
		s = {1'b0, h} + (ADDR_W+1)'(off);
		if (s >= (ADDR_W+1)'(DEPTH))
			s = s - (ADDR_W+1)'(DEPTH);
		return s[ADDR_W-1:0];
	endfunction

	assign accept    = req.valid && req.ready;
	assign advance   = s1_vld_q && (!out_vld_q || rsp.ready);
	assign req.ready = !s1_vld_q || advance;

	always_comb begin
		if (cap_q == '0)
			eff_cap = CNT_W'(1);
		else if (int'(cap_q) > DEPTH)
			eff_cap = CNT_W'(DEPTH);
		else
			eff_cap = CNT_W'(cap_q);
	end

	assign full  = fill_q >= eff_cap;
	assign empty = fill_q == '0;

	always_comb begin
		nxt_head = head_q;
		nxt_fill = fill_q;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		rd_addr  = head_q;
		rd_use   = 1'b0;
		st       = ST_OK;
		case (req.op)
			OP_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					nxt_head = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
					wr_en    = 1'b1;
					wr_addr  = nxt_head;
					nxt_fill = fill_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = ring_add(head_q, fill_q);
					nxt_fill = fill_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					rd_addr  = head_q;
					rd_use   = 1'b1;
					nxt_head = ring_add(head_q, CNT_W'(1));
					nxt_fill = fill_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					rd_addr  = ring_add(head_q, fill_q - 1'b1);
					rd_use   = 1'b1;
					nxt_fill = fill_q - 1'b1;
				end
			end
			OP_READ: begin
				if (int'(req.index) >= int'(fill_q)) begin
					st = ST_RANGE;
				end else begin
					rd_addr = ring_add(head_q, CNT_W'(req.index));
					rd_use  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// element memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && wr_en)
			mem[wr_addr] <= ELEM_BITS'(req.push_data);
		if (accept)
			mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			head_q <= nxt_head;
			fill_q <= nxt_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept)
				s1_vld_q <= 1'b1;
			else if (advance)
				s1_vld_q <= 1'b0;
			if (advance)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.use_rd <= rd_use;
			s1_q.status <= st;
			s1_q.count  <= nxt_fill;
		end
		if (advance) begin
			out_data_q   <= s1_q.use_rd ? DATA_W'(mem_rd_q) : '0;
			out_status_q <= s1_q.status;
			out_count_q  <= COUNT_W'(s1_q.count);
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.out_data = out_data_q;
	assign rsp.status   = out_status_q;
	assign rsp.count    = out_count_q;

endmodule

// File: rtl/core/rde_checker.sv
// Port-level checker of the ring deque engine, bound to the top level
`include "ring_deque_engine_assert.svh"

module rde_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic [rde_pkg::DATA_W-1:0]   rsp_data,
	input logic [rde_pkg::STAT_W-1:0]   rsp_status,
	input logic [rde_pkg::COUNT_W-1:0]  rsp_count
);
	import rde_pkg::*;

	// a failed request returns no element
	`RDE_ASSERT_NOW(a_err_no_data, rsp_valid && (rsp_status != ST_OK), rsp_data == '0, "error result carries data")
	// empty is only reported with nothing stored
	`RDE_ASSERT_NOW(a_empty_count, rsp_valid && (rsp_status == ST_EMPTY), rsp_count == '0, "empty status with nonzero count")
	// full needs at least one stored element
	`RDE_ASSERT_NOW(a_full_count, rsp_valid && (rsp_status == ST_FULL), rsp_count != '0, "full status with zero count")
	// an accepted request is followed by a visible result on rsp
	`RDE_ASSERT_LAT2(a_latency, req_valid && req_ready, rsp_valid, "result missing two cycles after request")

endmodule

bind ring_deque_engine rde_checker u_rde_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_data   (rsp.out_data),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count)
);

// File: tb/ring_deque_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the ring deque engine: directed table, then random capacity phases
module ring_deque_engine_tb;
	import rde_pkg::*;

	// op codes the block treats as no-ops
	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 60;
	localparam int PHASE_ITEMS    = 57;
	localparam int NUM_PHASES     = 11;
	localparam int MAX_REPORTS    = 40;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} deque_result_t;

	typedef struct packed {
		logic               is_cap;
		logic [CAP_W-1:0]   cap;
		logic [OP_W-1:0]    op;
		logic [DATA_W-1:0]  data;
		logic [IDX_W-1:0]   index;
		logic               fixed;
		deque_result_t      want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CAP_W-1:0]   cfg_wdata;

	rde_in_if  req_if();
	rde_out_if rsp_if();

	ring_deque_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// mirror of the deque
	logic [DATA_W-1:0]  ring_mirror [DEPTH];
	logic [ADDR_W-1:0]  mirror_head;
	logic [COUNT_W-1:0] mirror_fill;
	logic [CAP_W-1:0]   mirror_cap;

	deque_result_t pending_results [$];
	plan_row_t     directed_plan [$];
	logic [CAP_W-1:0] phase_cap [NUM_PHASES] =
		'{5'd31, 5'd16, 5'd1, 5'd0, 5'd2, 5'd9, 5'd16, 5'd5, 5'd31, 5'd13, 5'd16};

	int   fail_count;
	int   accepted_reqs;
	int   cap_writes;
	int   full_seen;
	int   empty_seen;
	int   range_seen;
	int   idle_cycles;
	logic gaps_on;
	logic long_hold_req;
	logic filling;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [COUNT_W-1:0] cap_limit();
		if (mirror_cap == '0)
			return COUNT_W'(1);
		if (mirror_cap > DEPTH)
			return COUNT_W'(DEPTH);
		return mirror_cap;
	endfunction

	function automatic deque_result_t deque_apply(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] data, input logic [IDX_W-1:0] index);
		deque_result_t r;
		logic full;
		logic empty;
		logic [ADDR_W-1:0] pos;
		r = '0;
		r.status = ST_OK;
		full = mirror_fill >= cap_limit();
		empty = mirror_fill == '0;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					mirror_head = mirror_head - 1'b1;
					ring_mirror[mirror_head] = data;
					mirror_fill = mirror_fill + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					pos = mirror_head + mirror_fill[ADDR_W-1:0];
					ring_mirror[pos] = data;
					mirror_fill = mirror_fill + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = ring_mirror[mirror_head];
					mirror_head = mirror_head + 1'b1;
					mirror_fill = mirror_fill - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					mirror_fill = mirror_fill - 1'b1;
					pos = mirror_head + mirror_fill[ADDR_W-1:0];
					r.data = ring_mirror[pos];
				end
			end
			OP_READ: begin
				if (index >= mirror_fill) begin
					r.status = ST_RANGE;
				end else begin
					pos = mirror_head + index;
					r.data = ring_mirror[pos];
				end
			end
			default: begin
			end
		endcase
		r.count = mirror_fill;
		case (r.status)
			ST_FULL:  full_seen++;
			ST_EMPTY: empty_seen++;
			ST_RANGE: range_seen++;
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic plan_row_t row_req(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] data, input logic [IDX_W-1:0] index);
		plan_row_t row;
		row = '0;
		row.op = op;
		row.data = data;
		row.index = index;
		return row;
	endfunction

	function automatic plan_row_t row_fix(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] data, input logic [IDX_W-1:0] index,
			input logic [DATA_W-1:0] want_data, input status_t want_status,
			input logic [COUNT_W-1:0] want_count);
		plan_row_t row;
		row = row_req(op, data, index);
		row.fixed = 1'b1;
		row.want.data = want_data;
		row.want.status = want_status;
		row.want.count = want_count;
		return row;
	endfunction

	function automatic plan_row_t row_cap(input logic [CAP_W-1:0] value);
		plan_row_t row;
		row = '0;
		row.is_cap = 1'b1;
		row.cap = value;
		return row;
	endfunction

	// mostly pushes while filling, mostly pops while draining, so both ends get hit
	function automatic plan_row_t random_row();
		plan_row_t row;
		int pick;
		row = '0;
		row.data = ($urandom_range(0, 9) == 0) ? {DATA_W{1'b1}} : $urandom();
		row.index = IDX_W'($urandom_range(0, DEPTH - 1));
		if (mirror_fill >= cap_limit())
			filling = 1'b0;
		else if (mirror_fill == '0)
			filling = 1'b1;
		else if ($urandom_range(0, 15) == 0)
			filling = !filling;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			row.op = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
		end else if (pick < 24) begin
			row.op = OP_READ;
			if (mirror_fill != '0 && $urandom_range(0, 7) != 0)
				row.index = IDX_W'($urandom_range(0, mirror_fill - 1));
		end else if ((pick < 80) == filling) begin
			row.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		end else begin
			row.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		end
		return row;
	endfunction

	task automatic issue_request(input plan_row_t row);
		deque_result_t predicted;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.op        <= row.op;
		req_if.push_data <= row.data;
		req_if.index     <= row.index;
		do @(posedge clk); while (!req_if.ready);
		predicted = deque_apply(row.op, row.data, row.index);
		pending_results.push_back(row.fixed ? row.want : predicted);
		accepted_reqs++;
	endtask

	// capacity only changes with nothing in flight
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_cap = value;
		cap_writes++;
	endtask

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want_v,
			input logic [DATA_W-1:0] got_v);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
	endtask

	always @(posedge clk) begin : check_results
		deque_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, got data %0h status %0d count %0d",
						$time, rsp_if.out_data, rsp_if.status, rsp_if.count);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.out_data !== want.data)
					report_mismatch("out_data", want.data, rsp_if.out_data);
				if (rsp_if.status !== want.status)
					report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_if.status));
				if (rsp_if.count !== want.count)
					report_mismatch("count", DATA_W'(want.count), DATA_W'(rsp_if.count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, nothing moved for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending_results.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// response side: random stalls, plus one long hold-off to back the block up
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 6) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int counted;
		plan_row_t row;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = CAP_RESET;
		req_if.valid     = 1'b0;
		req_if.op        = OP_PUSH_FRONT;
		req_if.push_data = '0;
		req_if.index     = '0;
		gaps_on          = 1'b1;
		long_hold_req    = 1'b0;
		filling          = 1'b1;
		fail_count       = 0;
		accepted_reqs    = 0;
		cap_writes       = 0;
		full_seen        = 0;
		empty_seen       = 0;
		range_seen       = 0;
		mirror_head      = '0;
		mirror_fill      = '0;
		mirror_cap       = CAP_RESET;

		directed_plan = '{
			row_fix(OP_POP_FRONT, 32'h0, 4'd0, 32'h0, ST_EMPTY, 5'd0),
			row_fix(OP_POP_BACK, 32'h0, 4'd0, 32'h0, ST_EMPTY, 5'd0),
			row_fix(OP_READ, 32'h0, 4'd0, 32'h0, ST_RANGE, 5'd0),
			row_fix(OP_READ, 32'h0, 4'd15, 32'h0, ST_RANGE, 5'd0),
			row_fix(OP_RSVD_5, 32'hFFFF_FFFF, 4'd15, 32'h0, ST_OK, 5'd0),
			row_fix(OP_RSVD_7, 32'h0, 4'd0, 32'h0, ST_OK, 5'd0),
			row_fix(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd15, 32'h0, ST_OK, 5'd1),
			// head wraps below zero here
			row_fix(OP_PUSH_FRONT, 32'h0000_0000, 4'd0, 32'h0, ST_OK, 5'd2),
			row_fix(OP_PUSH_FRONT, 32'hA5A5_A5A5, 4'd0, 32'h0, ST_OK, 5'd3),
			row_req(OP_READ, 32'h0, 4'd0),
			row_req(OP_READ, 32'h0, 4'd2),
			row_fix(OP_READ, 32'h0, 4'd3, 32'h0, ST_RANGE, 5'd3),
			row_fix(OP_RSVD_6, 32'h1234_5678, 4'd1, 32'h0, ST_OK, 5'd3),
			// capacity dropped under the count: contents stay, pushes report full
			row_cap(5'd1),
			row_fix(OP_PUSH_BACK, 32'h1234_5678, 4'd0, 32'h0, ST_FULL, 5'd3),
			row_fix(OP_PUSH_FRONT, 32'h8765_4321, 4'd0, 32'h0, ST_FULL, 5'd3),
			row_req(OP_POP_BACK, 32'h0, 4'd0),
			row_req(OP_POP_FRONT, 32'h0, 4'd0),
			row_fix(OP_PUSH_BACK, 32'hDEAD_BEEF, 4'd0, 32'h0, ST_FULL, 5'd1),
			row_req(OP_READ, 32'h0, 4'd0),
			row_req(OP_POP_FRONT, 32'h0, 4'd0),
			row_fix(OP_PUSH_FRONT, 32'h5A5A_5A5A, 4'd0, 32'h0, ST_OK, 5'd1),
			row_fix(OP_PUSH_BACK, 32'h0F0F_0F0F, 4'd0, 32'h0, ST_FULL, 5'd1),
			// zero capacity behaves as one
			row_cap(5'd0),
			row_fix(OP_PUSH_BACK, 32'hC3C3_C3C3, 4'd0, 32'h0, ST_FULL, 5'd1),
			row_req(OP_POP_BACK, 32'h0, 4'd0),
			row_fix(OP_POP_BACK, 32'h0, 4'd0, 32'h0, ST_EMPTY, 5'd0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cap)
				write_capacity(directed_plan[i].cap);
			else
				issue_request(directed_plan[i]);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(phase_cap[p]);
			if (p == 1)
				long_hold_req <= 1'b1;
			if (p == NUM_PHASES - 1)
				gaps_on <= 1'b0;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				row = random_row();
				issue_request(row);
				if (row.op <= OP_READ)
					counted++;
			end
		end

		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests across %0d capacity writes", accepted_reqs, cap_writes);
		$display("Rejected requests seen: %0d full, %0d empty, %0d out of range",
			full_seen, empty_seen, range_seen);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
